### sv/qbdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbdp_pkg
// Shared types and constants of the block-quantized dot product unit.
// ----------------------------------------------------------------------------
package qbdp_pkg;

	// field widths
	localparam int unsigned WB_W    = 16;
	localparam int unsigned ACT_W   = 16;
	localparam int unsigned SCALE_W = 32;
	localparam int unsigned TOTAL_W = 64;

	// one nibble weight and its offset in Q4_0
	localparam int unsigned NIB_W = 4;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WGT_W = 9;
	localparam logic signed [WGT_W-1:0] Q4_OFFSET = 9'sd8;

	// datapath widths
	localparam int unsigned PROD_W  = 24;  // int8 times Q4.12
	localparam int unsigned PAIR_W  = 25;  // two lane products
	localparam int unsigned SUM_W   = 34;  // block sum, wraps
	localparam int unsigned LO_W    = 17;  // low half of the block sum split
	localparam int unsigned HI_W    = SUM_W - LO_W;
	localparam int unsigned PP_W    = 49;  // partial product width
	localparam int unsigned BPROD_W = 66;  // full block sum times scale
	localparam int unsigned ACC_W   = 67;  // total plus block product

	// weight format register codes
	localparam logic WFMT_Q8 = 1'b0;
	localparam logic WFMT_Q4 = 1'b1;

	// saturation limits
	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

	// control travelling down the pipeline
	typedef struct packed {
		logic valid;
		logic close;  // block ends here (block end or vector end)
		logic vend;   // vector ends here, result is emitted
	} ctrl_t;

endpackage

### sv/quantized_block_dot_product_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_block_dot_product_unit
// Q8_0 / Q4_0 block-quantized dot product with saturating 64-bit total.
//
// channel  | dir | fields (lowest bit up)
// s_*      | in  | tdata: weight_bits, act_even, act_odd, block_scale;
//          |     | tuser: odd_present, block_end; tlast: vector_end
// m_*      | out | tdata: dot_total; tuser: overflow
// cfg_*    | in  | weight_format
//
// One element pair is taken every cycle unless the pipeline holds. A result is
// valid at the master side after the vector end passes five register stages:
// the lane multiply, the block sum merge, the two halves of the split
// block-scale multiply and the saturating total add into the output register.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the block sum, the total, the overflow flag and the format.
// ----------------------------------------------------------------------------
module quantized_block_dot_product_unit (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         cfg_we,
	input  logic         cfg_wdata,      // weight_format
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,        // weight_bits, act_even, act_odd, block_scale
	input  logic [1:0]   s_tuser,        // odd_present, block_end
	input  logic         s_tlast,        // vector_end
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,        // dot_total
	output logic [0:0]   m_tuser         // overflow
);

	logic                                   weight_format_q;
	logic                                   en;
	logic [qbdp_pkg::WB_W-1:0]              weight_bits;
	logic signed [qbdp_pkg::ACT_W-1:0]      act_even;
	logic signed [qbdp_pkg::ACT_W-1:0]      act_odd;
	logic signed [qbdp_pkg::SCALE_W-1:0]    block_scale;

	qbdp_pkg::ctrl_t                        ctrl_s1;
	qbdp_pkg::ctrl_t                        ctrl_s2;
	qbdp_pkg::ctrl_t                        ctrl_s4;
	logic signed [qbdp_pkg::SCALE_W-1:0]    scale_s1;
	logic signed [qbdp_pkg::SCALE_W-1:0]    scale_s2;
	logic signed [qbdp_pkg::PROD_W-1:0]     prod_even_s1;
	logic signed [qbdp_pkg::PROD_W-1:0]     prod_odd_s1;
	logic signed [qbdp_pkg::SUM_W-1:0]      close_sum_s2;
	logic signed [qbdp_pkg::BPROD_W-1:0]    prod_s4;

	logic signed [qbdp_pkg::TOTAL_W-1:0]    total_q;
	logic                                   sat_q;
	logic signed [qbdp_pkg::ACC_W-1:0]      acc_sum;
	logic                                   acc_ovf;
	logic signed [qbdp_pkg::TOTAL_W-1:0]    total_next;
	logic                                   sat_next;

	logic                                   m_tvalid_q;
	logic [qbdp_pkg::TOTAL_W-1:0]           m_total_q;
	logic                                   m_ovf_q;

	// field unpacking
	assign weight_bits = s_tdata[15:0];
	assign act_even    = $signed(s_tdata[31:16]);
	assign act_odd     = $signed(s_tdata[47:32]);
	assign block_scale = $signed(s_tdata[79:48]);

	// pipeline advances whenever the output register can take a transaction
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_format_q <= qbdp_pkg::WFMT_Q8;
		end else if (cfg_we) begin
			weight_format_q <= cfg_wdata;
		end
	end

	// stage 1 control and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1.valid <= s_tvalid;
			ctrl_s1.close <= s_tuser[1] || s_tlast;
			ctrl_s1.vend  <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s1 <= block_scale;
		end
	end

	// element lanes
	qbdp_lane u_lane_even (
		.clk           (clk),
		.load          (en),
		.weight_format (weight_format_q),
		.wbyte         (weight_bits[qbdp_pkg::BYTE_W-1:0]),
		.wnib          (weight_bits[qbdp_pkg::NIB_W-1:0]),
		.act           (act_even),
		.active        (1'b1),
		.prod_s1       (prod_even_s1)
	);

	qbdp_lane u_lane_odd (
		.clk           (clk),
		.load          (en),
		.weight_format (weight_format_q),
		.wbyte         (weight_bits[2*qbdp_pkg::BYTE_W-1:qbdp_pkg::BYTE_W]),
		.wnib          (weight_bits[2*qbdp_pkg::NIB_W-1:qbdp_pkg::NIB_W]),
		.act           (act_odd),
		.active        (s_tuser[0]),
		.prod_s1       (prod_odd_s1)
	);

	// lane merge and block sum
	qbdp_block_acc u_block_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.ctrl_s1      (ctrl_s1),
		.prod_even_s1 (prod_even_s1),
		.prod_odd_s1  (prod_odd_s1),
		.scale_s1     (scale_s1),
		.ctrl_s2      (ctrl_s2),
		.close_sum_s2 (close_sum_s2),
		.scale_s2     (scale_s2)
	);

	// block scaling
	qbdp_scale_mul u_scale_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_s2  (ctrl_s2),
		.sum_s2   (close_sum_s2),
		.scale_s2 (scale_s2),
		.ctrl_s4  (ctrl_s4),
		.prod_s4  (prod_s4)
	);

	// saturating total: exact sum, out of range when the top bits disagree
	assign acc_sum = qbdp_pkg::ACC_W'(total_q) + qbdp_pkg::ACC_W'(prod_s4);
	assign acc_ovf = !((acc_sum[qbdp_pkg::ACC_W-1:qbdp_pkg::TOTAL_W-1] == '0)
		|| (acc_sum[qbdp_pkg::ACC_W-1:qbdp_pkg::TOTAL_W-1] == '1));

	always_comb begin
		if (acc_ovf) begin
			total_next = acc_sum[qbdp_pkg::ACC_W-1] ? qbdp_pkg::TOTAL_MIN : qbdp_pkg::TOTAL_MAX;
		end else begin
			total_next = $signed(acc_sum[qbdp_pkg::TOTAL_W-1:0]);
		end
		sat_next = sat_q || acc_ovf;
	end

	// running total and overflow flag, cleared at vector end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			sat_q   <= 1'b0;
		end else if (en && ctrl_s4.valid && ctrl_s4.close) begin
			if (ctrl_s4.vend) begin
				total_q <= '0;
				sat_q   <= 1'b0;
			end else begin
				total_q <= total_next;
				sat_q   <= sat_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= ctrl_s4.valid && ctrl_s4.vend;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctrl_s4.valid && ctrl_s4.vend) begin
			m_total_q <= total_next;
			m_ovf_q   <= sat_next;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_total_q;
	assign m_tuser[0] = m_ovf_q;

	// a result only appears after a vector end reached the last stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(ctrl_s4.valid && ctrl_s4.vend))
		else $error("result without a vector end in the last stage");

	// emitting a result leaves a clean total and flag
	a_total_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctrl_s4.valid && ctrl_s4.vend) |=> (total_q == '0 && !sat_q))
		else $error("total not cleared after vector end");

	// only a closing block hands a nonzero sum to the multiplier
	a_open_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s2.valid && !ctrl_s2.close) |-> (close_sum_s2 == '0))
		else $error("open block leaked into the scale multiply");

endmodule

### sv/qbdp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbdp_lane
// One element lane: decodes a Q8_0 or Q4_0 weight and multiplies it by its
// activation, result registered.
// ----------------------------------------------------------------------------
module qbdp_lane (
	input  logic                                     clk,
	input  logic                                     load,
	input  logic                                     weight_format,
	input  logic [qbdp_pkg::BYTE_W-1:0]              wbyte,
	input  logic [qbdp_pkg::NIB_W-1:0]               wnib,
	input  logic signed [qbdp_pkg::ACT_W-1:0]        act,
	input  logic                                     active,
	output logic signed [qbdp_pkg::PROD_W-1:0]       prod_s1
);

	logic signed [qbdp_pkg::WGT_W-1:0] wgt;
	logic signed [qbdp_pkg::PAIR_W-1:0] prod_full;

	// weight decode
	always_comb begin
		unique case (weight_format)
			qbdp_pkg::WFMT_Q8: wgt = $signed({wbyte[qbdp_pkg::BYTE_W-1], wbyte});
			qbdp_pkg::WFMT_Q4: wgt = $signed({{(qbdp_pkg::WGT_W-qbdp_pkg::NIB_W){1'b0}}, wnib})
				- qbdp_pkg::Q4_OFFSET;
			default:           wgt = '0;
		endcase
	end

	// narrow multiply, fits in PROD_W bits
	assign prod_full = wgt * act;

	// lane product register
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= active ? $signed(prod_full[qbdp_pkg::PROD_W-1:0]) : '0;
		end
	end

endmodule

### sv/qbdp_block_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbdp_block_acc
// Merges the two lane products and accumulates the block sum; hands the
// finished block sum downstream when the block closes.
// ----------------------------------------------------------------------------
module qbdp_block_acc (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  qbdp_pkg::ctrl_t                          ctrl_s1,
	input  logic signed [qbdp_pkg::PROD_W-1:0]       prod_even_s1,
	input  logic signed [qbdp_pkg::PROD_W-1:0]       prod_odd_s1,
	input  logic signed [qbdp_pkg::SCALE_W-1:0]      scale_s1,
	output qbdp_pkg::ctrl_t                          ctrl_s2,
	output logic signed [qbdp_pkg::SUM_W-1:0]        close_sum_s2,
	output logic signed [qbdp_pkg::SCALE_W-1:0]      scale_s2
);

	logic signed [qbdp_pkg::SUM_W-1:0]  block_sum_q;
	logic signed [qbdp_pkg::PAIR_W-1:0] pair_sum;
	logic signed [qbdp_pkg::SUM_W-1:0]  sum_next;

	// merge the lanes, then add into the block sum (wraps at SUM_W)
	assign pair_sum = qbdp_pkg::PAIR_W'(prod_even_s1) + qbdp_pkg::PAIR_W'(prod_odd_s1);
	assign sum_next = block_sum_q + qbdp_pkg::SUM_W'(pair_sum);

	// block sum accumulator, cleared when the block closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_sum_q <= '0;
			ctrl_s2     <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
			if (ctrl_s1.valid) begin
				block_sum_q <= ctrl_s1.close ? '0 : sum_next;
			end
		end
	end

	// closed block sum and its scale
	always_ff @(posedge clk) begin
		if (en) begin
			close_sum_s2 <= (ctrl_s1.valid && ctrl_s1.close) ? sum_next : '0;
			scale_s2     <= scale_s1;
		end
	end

endmodule

### sv/qbdp_scale_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbdp_scale_mul
// Block sum times block scale in two stages: two 17 by 32 bit partial
// products, then a shifted add into the full 66-bit product.
// ----------------------------------------------------------------------------
module qbdp_scale_mul (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  qbdp_pkg::ctrl_t                          ctrl_s2,
	input  logic signed [qbdp_pkg::SUM_W-1:0]        sum_s2,
	input  logic signed [qbdp_pkg::SCALE_W-1:0]      scale_s2,
	output qbdp_pkg::ctrl_t                          ctrl_s4,
	output logic signed [qbdp_pkg::BPROD_W-1:0]      prod_s4
);

	qbdp_pkg::ctrl_t                     ctrl_s3;
	logic signed [qbdp_pkg::PP_W-1:0]    pp_lo;
	logic signed [qbdp_pkg::PP_W-1:0]    pp_hi;
	logic signed [qbdp_pkg::PP_W-1:0]    pp_lo_s3;
	logic signed [qbdp_pkg::PP_W-1:0]    pp_hi_s3;

	// low half taken unsigned, high half signed
	assign pp_lo = $signed({1'b0, sum_s2[qbdp_pkg::LO_W-1:0]}) * scale_s2;
	assign pp_hi = $signed(sum_s2[qbdp_pkg::SUM_W-1:qbdp_pkg::LO_W]) * scale_s2;

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else if (en) begin
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
		end
	end

	// partial products, then recombine
	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s3 <= pp_lo;
			pp_hi_s3 <= pp_hi;
			prod_s4  <= (qbdp_pkg::BPROD_W'(pp_hi_s3) <<< qbdp_pkg::LO_W)
				+ qbdp_pkg::BPROD_W'(pp_lo_s3);
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block-quantized dot product unit. Element
// pairs stream in over the slave channel; a local model of the Q8_0 / Q4_0
// block accumulation and the saturating total predicts every emitted dot
// product, which is compared field by field with the master channel. A
// directed table covers the extremes, both weight formats and the corner
// cases; random vectors, malformed runs and long full-scale runs that
// saturate the total follow, under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SEG_ITEMS    = 25;
	localparam int MAX_REPORTS  = 10;

	// one element pair as it enters the unit
	typedef struct {
		logic [qbdp_pkg::WB_W-1:0]           wbits;
		logic signed [qbdp_pkg::ACT_W-1:0]   act_even;
		logic signed [qbdp_pkg::ACT_W-1:0]   act_odd;
		logic                                odd_present;
		logic signed [qbdp_pkg::SCALE_W-1:0] scale;
		logic                                block_end;
		logic                                vector_end;
	} pair_t;

	// one emitted dot product
	typedef struct {
		logic [qbdp_pkg::TOTAL_W-1:0] total;
		logic                         ovf;
	} dot_res_t;

	// directed stimulus row, with a typed-in result where it is obvious
	typedef struct {
		logic     wfmt;
		pair_t    pair;
		bit       typed;
		dot_res_t res;
	} dir_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic                cfg_wdata = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [79:0]         s_tdata   = '0;   // weight_bits, act_even, act_odd, block_scale
	logic [1:0]          s_tuser   = '0;   // odd_present, block_end
	logic                s_tlast   = 1'b0; // vector_end
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [63:0]         m_tdata;          // dot_total
	logic [0:0]          m_tuser;          // overflow

	int send_idle_pct = 19;
	int recv_idle_pct = 88;
	int error_count   = 0;
	int cycle_count   = 0;

	// model state
	logic                                wfmt      = qbdp_pkg::WFMT_Q8;
	logic signed [qbdp_pkg::SUM_W-1:0]   blk_sum   = '0;
	logic signed [qbdp_pkg::TOTAL_W-1:0] run_total = '0;
	logic                                sat_seen  = 1'b0;

	dot_res_t expected_totals[$];

	quantized_block_dot_product_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// dot product model: one pair in, at most one total out
	task automatic dot_step(input pair_t p, output bit emit, output dot_res_t res);
		logic signed [qbdp_pkg::WGT_W-1:0] w_even;
		logic signed [qbdp_pkg::WGT_W-1:0] w_odd;
		logic signed [qbdp_pkg::SUM_W-1:0] lane_even;
		logic signed [qbdp_pkg::SUM_W-1:0] lane_odd;
		logic signed [qbdp_pkg::ACC_W:0]   acc;
		emit      = 1'b0;
		res.total = '0;
		res.ovf   = 1'b0;
		// decode the two weights
		if (wfmt == qbdp_pkg::WFMT_Q4) begin
			w_even = $signed({{(qbdp_pkg::WGT_W-qbdp_pkg::NIB_W){1'b0}},
				p.wbits[qbdp_pkg::NIB_W-1:0]}) - qbdp_pkg::Q4_OFFSET;
			w_odd  = $signed({{(qbdp_pkg::WGT_W-qbdp_pkg::NIB_W){1'b0}},
				p.wbits[2*qbdp_pkg::NIB_W-1:qbdp_pkg::NIB_W]}) - qbdp_pkg::Q4_OFFSET;
		end else begin
			w_even = $signed({p.wbits[qbdp_pkg::BYTE_W-1],
				p.wbits[qbdp_pkg::BYTE_W-1:0]});
			w_odd  = $signed({p.wbits[qbdp_pkg::WB_W-1],
				p.wbits[qbdp_pkg::WB_W-1:qbdp_pkg::BYTE_W]});
		end
		// lane products into the wrapping block sum
		lane_even = w_even * p.act_even;
		lane_odd  = '0;
		if (p.odd_present)
			lane_odd = w_odd * p.act_odd;
		blk_sum = blk_sum + lane_even + lane_odd;
		// block close: exact scaled sum into the saturating total
		if (p.block_end || p.vector_end) begin
			acc = blk_sum * p.scale;
			acc = acc + run_total;
			if (acc > qbdp_pkg::TOTAL_MAX) begin
				run_total = qbdp_pkg::TOTAL_MAX;
				sat_seen  = 1'b1;
			end else if (acc < qbdp_pkg::TOTAL_MIN) begin
				run_total = qbdp_pkg::TOTAL_MIN;
				sat_seen  = 1'b1;
			end else begin
				run_total = acc[qbdp_pkg::TOTAL_W-1:0];
			end
			blk_sum = '0;
		end
		// vector end: emit and clear
		if (p.vector_end) begin
			emit      = 1'b1;
			res.total = run_total;
			res.ovf   = sat_seen;
			run_total = '0;
			sat_seen  = 1'b0;
			blk_sum   = '0;
		end
	endtask

	// drive one pair, wait for its transaction, then predict
	task automatic send_pair(input pair_t p, input bit typed, input dot_res_t typed_res);
		bit       emit;
		dot_res_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.scale, p.act_odd, p.act_even, p.wbits};
		s_tuser  <= {p.block_end, p.odd_present};
		s_tlast  <= p.vector_end;
		do @(posedge clk); while (!s_tready);
		dot_step(p, emit, res);
		if (emit)
			expected_totals.push_back(typed ? typed_res : res);
	endtask

	// let every result out, then write the format register
	task automatic set_format(input logic value);
		s_tvalid <= 1'b0;
		while (expected_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		wfmt      = value;
	endtask

	function automatic logic [qbdp_pkg::ACT_W-1:0] rand_act();
		case ($urandom_range(7))
			0:       rand_act = 16'h8000;
			1:       rand_act = 16'h7FFF;
			default: rand_act = 16'($urandom);
		endcase
	endfunction

	function automatic logic [qbdp_pkg::SCALE_W-1:0] rand_scale();
		case ($urandom_range(9))
			0:             rand_scale = 32'h8000_0000;
			1:             rand_scale = 32'h7FFF_FFFF;
			2:             rand_scale = 32'hFFFF_FFFF;
			3, 4, 5:       rand_scale = $urandom;
			default:       rand_scale = $urandom_range(0, 2 ** 21) - 2 ** 20;
		endcase
	endfunction

	function automatic dir_row_t mk_row(input logic f, input logic [15:0] wb,
		input logic [15:0] ae, input logic [15:0] ao, input logic odd,
		input logic [31:0] sc, input logic be, input logic ve, input bit typed,
		input logic [63:0] tot, input logic ovf);
		mk_row.wfmt             = f;
		mk_row.pair.wbits       = wb;
		mk_row.pair.act_even    = ae;
		mk_row.pair.act_odd     = ao;
		mk_row.pair.odd_present = odd;
		mk_row.pair.scale       = sc;
		mk_row.pair.block_end   = be;
		mk_row.pair.vector_end  = ve;
		mk_row.typed            = typed;
		mk_row.res.total        = tot;
		mk_row.res.ovf          = ovf;
	endfunction

	// well-formed vector: random blocks, random content
	task automatic send_vector(input int n_pairs);
		pair_t                        p;
		int                           left_in_block;
		logic [qbdp_pkg::SCALE_W-1:0] blk_scale;
		dot_res_t                     none;
		none.total    = '0;
		none.ovf      = 1'b0;
		left_in_block = 0;
		blk_scale     = '0;
		for (int i = 0; i < n_pairs; i++) begin
			if (left_in_block == 0) begin
				left_in_block = ($urandom_range(9) == 0) ? $urandom_range(33, 48)
					: $urandom_range(1, 32);
				blk_scale = rand_scale();
			end
			left_in_block--;
			p.wbits       = 16'($urandom);
			p.act_even    = rand_act();
			p.act_odd     = rand_act();
			p.odd_present = ($urandom_range(4) != 0);
			p.scale       = blk_scale;
			p.block_end   = (left_in_block == 0);
			p.vector_end  = (i == n_pairs - 1);
			// the vector end may or may not also flag the block end
			if (p.vector_end)
				p.block_end = 1'($urandom_range(1));
			send_pair(p, 1'b0, none);
		end
	endtask

	// malformed run: every field random, closed by a vector end
	task automatic send_noise(input int n_pairs);
		pair_t    p;
		dot_res_t none;
		none.total = '0;
		none.ovf   = 1'b0;
		for (int i = 0; i < n_pairs; i++) begin
			p.wbits       = 16'($urandom);
			p.act_even    = 16'($urandom);
			p.act_odd     = 16'($urandom);
			p.odd_present = 1'($urandom_range(1));
			p.scale       = $urandom;
			p.block_end   = 1'($urandom_range(1));
			p.vector_end  = (i == n_pairs - 1) ? 1'b1 : ($urandom_range(5) == 0);
			send_pair(p, 1'b0, none);
		end
	endtask

	// full-scale pairs, for total saturation
	task automatic send_max_blocks(input int n_blocks, input int blk_len,
		input logic [qbdp_pkg::SCALE_W-1:0] scale, input bit close_vector);
		pair_t    p;
		dot_res_t none;
		none.total    = '0;
		none.ovf      = 1'b0;
		p.wbits       = 16'h8080;
		p.act_even    = 16'h8000;
		p.act_odd     = 16'h8000;
		p.odd_present = 1'b1;
		p.scale       = scale;
		for (int b = 0; b < n_blocks; b++) begin
			for (int i = 0; i < blk_len; i++) begin
				p.block_end  = (i == blk_len - 1);
				p.vector_end = close_vector && p.block_end && (b == n_blocks - 1);
				send_pair(p, 1'b0, none);
			end
		end
	endtask

	task automatic run_segment(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				len = $urandom_range(1, 4);
				send_noise(len);
			end else begin
				len = ($urandom_range(7) == 0) ? $urandom_range(41, 70) : $urandom_range(1, 40);
				send_vector(len);
			end
			sent += len;
		end
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin : result_check
		dot_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_totals.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected result: total %h ovf %b", m_tdata, m_tuser[0]);
			end else begin
				want = expected_totals.pop_front();
				if (m_tdata !== want.total || m_tuser[0] !== want.ovf) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("mismatch: expected total %h ovf %b, got total %h ovf %b",
							want.total, want.ovf, m_tdata, m_tuser[0]);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// stimulus
	initial begin : stimulus
		dir_row_t rows[$];
		// Q8_0 rows
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'h0000, 16'h0000, 16'h0000, 1'b0,
			32'h0000_0000, 1'b0, 1'b1, 1'b1, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'h0101, 16'h1000, 16'h1000, 1'b1,
			32'h0001_0000, 1'b1, 1'b1, 1'b1, 64'h2000_0000, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'h8080, 16'h8000, 16'h8000, 1'b1,
			32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0));
		// missing odd element, vector end without block end
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'h7F7F, 16'h7FFF, 16'h7FFF, 1'b0,
			32'h8000_0000, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0));
		// several blocks in one vector
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'h80FF, 16'h5A5A, 16'hA5A5, 1'b1,
			32'h0003_8000, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'h7F01, 16'hC000, 16'h3FFF, 1'b1,
			32'h1234_5678, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'hFE7F, 16'h0FFF, 16'hF001, 1'b1,
			32'hFFFE_0000, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q8, 16'h00FF, 16'h1000, 16'h7FFF, 1'b0,
			32'h0001_0000, 1'b1, 1'b1, 1'b1, 64'hFFFF_FFFF_F000_0000, 1'b0));
		// Q4_0 rows, the high byte is ignored
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q4, 16'hAB99, 16'h1000, 16'h1000, 1'b1,
			32'h0001_0000, 1'b1, 1'b1, 1'b1, 64'h2000_0000, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q4, 16'h00F0, 16'h8000, 16'h7FFF, 1'b1,
			32'h8000_0000, 1'b1, 1'b1, 1'b0, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q4, 16'hFF0F, 16'h7FFF, 16'h8000, 1'b0,
			32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q4, 16'h0000, 16'h8000, 16'h8000, 1'b1,
			32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q4, 16'hFFFF, 16'h8000, 16'h8000, 1'b1,
			32'h0000_0001, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0));
		rows.push_back(mk_row(qbdp_pkg::WFMT_Q4, 16'h1234, 16'h4321, 16'h7777, 1'b1,
			32'h0000_0000, 1'b1, 1'b1, 1'b1, 64'h0, 1'b0));

		// reset
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		set_format(qbdp_pkg::WFMT_Q8);
		foreach (rows[i]) begin
			if (rows[i].wfmt != wfmt)
				set_format(rows[i].wfmt);
			send_pair(rows[i].pair, rows[i].typed, rows[i].res);
		end

		// random vectors under three idling patterns
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				set_format((seg % 2 == 1) ^ (ph == 1));
				run_segment(SEG_ITEMS);
			end
		end

		// full-scale blocks land exactly on the most negative total
		set_format(qbdp_pkg::WFMT_Q8);
		send_max_blocks(16, 32, 32'h8000_0000, 1'b0);
		// one more pair saturates low, flag stays set through later blocks
		send_max_blocks(1, 1, 32'h8000_0000, 1'b0);
		send_max_blocks(2, 1, 32'h7FFF_FFFF, 1'b1);

		// wait for every result, then the pipeline tail
		s_tvalid <= 1'b0;
		while (expected_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_totals.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
